// ===== sv/ebc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ebc_pkg;
  localparam logic [3:0] FLAG_Z = 4'h8;
  localparam logic [3:0] FLAG_N = 4'h4;
  localparam logic [3:0] FLAG_H = 4'h2;
  localparam logic [3:0] FLAG_C = 4'h1;

  localparam logic [2:0] PH_START = 3'd0;
  localparam logic [2:0] PH_OPC   = 3'd1;
  localparam logic [2:0] PH_2     = 3'd2;
  localparam logic [2:0] PH_3     = 3'd3;
  localparam logic [2:0] PH_4     = 3'd4;
  localparam logic [2:0] PH_5     = 3'd5;

  localparam logic [0:0] CFG_START_ADDRESS = 1'b0;
  localparam logic [0:0] CFG_START_STACK   = 1'b1;

  localparam logic [7:0] OP_NOP      = 8'h00;
  localparam logic [7:0] OP_INC_BC   = 8'h03;
  localparam logic [7:0] OP_LD_B_N   = 8'h06;
  localparam logic [7:0] OP_LD_NN_SP = 8'h08;
  localparam logic [7:0] OP_DEC_BC   = 8'h0B;
  localparam logic [7:0] OP_INC_C    = 8'h0C;
  localparam logic [7:0] OP_DEC_C    = 8'h0D;
  localparam logic [7:0] OP_LD_C_N   = 8'h0E;
  localparam logic [7:0] OP_STOP     = 8'h10;
  localparam logic [7:0] OP_LD_DE_NN = 8'h11;
  localparam logic [7:0] OP_RLA      = 8'h17;
  localparam logic [7:0] OP_LD_A_DE  = 8'h1A;
  localparam logic [7:0] OP_RRA      = 8'h1F;
  localparam logic [7:0] OP_JR_NZ    = 8'h20;
  localparam logic [7:0] OP_LD_HL_NN = 8'h21;
  localparam logic [7:0] OP_LD_H_N   = 8'h26;
  localparam logic [7:0] OP_LD_SP_NN = 8'h31;
  localparam logic [7:0] OP_LDD_HL_A = 8'h32;
  localparam logic [7:0] OP_INC_SP   = 8'h33;
  localparam logic [7:0] OP_LD_A_N   = 8'h3E;
  localparam logic [7:0] OP_LD_C_A   = 8'h4F;
  localparam logic [7:0] OP_LD_H_E   = 8'h63;
  localparam logic [7:0] OP_LD_H_HL  = 8'h66;
  localparam logic [7:0] OP_LD_H_A   = 8'h67;
  localparam logic [7:0] OP_LD_L_HL  = 8'h6E;
  localparam logic [7:0] OP_LD_HL_E  = 8'h73;
  localparam logic [7:0] OP_LD_HL_A  = 8'h77;
  localparam logic [7:0] OP_ADD_E    = 8'h83;
  localparam logic [7:0] OP_ADC_B    = 8'h88;
  localparam logic [7:0] OP_ADC_C    = 8'h89;
  localparam logic [7:0] OP_SBC_C    = 8'h99;
  localparam logic [7:0] OP_SBC_A    = 8'h9F;
  localparam logic [7:0] OP_XOR_A    = 8'hAF;
  localparam logic [7:0] OP_CP_C     = 8'hB9;
  localparam logic [7:0] OP_CP_E     = 8'hBB;
  localparam logic [7:0] OP_POP_BC   = 8'hC1;
  localparam logic [7:0] OP_PUSH_BC  = 8'hC5;
  localparam logic [7:0] OP_PREFIX   = 8'hCB;
  localparam logic [7:0] OP_CALL_Z   = 8'hCC;
  localparam logic [7:0] OP_CALL     = 8'hCD;
  localparam logic [7:0] OP_ADC_N    = 8'hCE;
  localparam logic [7:0] OP_RETI     = 8'hD9;
  localparam logic [7:0] OP_CALL_C   = 8'hDC;
  localparam logic [7:0] OP_LDH_N_A  = 8'hE0;
  localparam logic [7:0] OP_POP_HL   = 8'hE1;
  localparam logic [7:0] OP_LDH_C_A  = 8'hE2;
  localparam logic [7:0] OP_AND_N    = 8'hE6;
  localparam logic [7:0] CB_RL_C     = 8'h11;
  localparam logic [7:0] CB_BIT7_H   = 8'h7C;

  typedef struct packed {
    logic [7:0]  a;
    logic [3:0]  f;
    logic [7:0]  b;
    logic [7:0]  c;
    logic [7:0]  d;
    logic [7:0]  e;
    logic [7:0]  h;
    logic [7:0]  l;
    logic [15:0] sp;
    logic [15:0] pc;
    logic        ime;
    logic        cb;
    logic        halt;
    logic [7:0]  op;
    logic [15:0] imm;
    logic [2:0]  ph;
  } cpu_state_t;

  typedef struct packed {
    logic [15:0] addr;
    logic        wr;
    logic [7:0]  wdata;
    logic        done;
    logic        stopped;
  } bus_req_t;

  typedef struct packed {
    logic [7:0] a;
    logic [3:0] f;
  } alu_res_t;

  function automatic alu_res_t alu_add(input logic [7:0] a, input logic [7:0] b,
                                       input logic cin);
    logic [8:0] r;
    logic [4:0] hs;
    alu_res_t o;
    r = {1'b0, a} + {1'b0, b} + {8'd0, cin};
    hs = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
    o.a = r[7:0];
    o.f = {r[7:0] == 8'd0, 1'b0, hs[4], r[8]};
    return o;
  endfunction

  function automatic alu_res_t alu_sub(input logic [7:0] a, input logic [7:0] b,
                                       input logic cin);
    logic [8:0] r;
    logic [4:0] hs;
    alu_res_t o;
    r = {1'b0, a} - {1'b0, b} - {8'd0, cin};
    hs = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cin};
    o.a = r[7:0];
    o.f = {r[7:0] == 8'd0, 1'b1, hs[4], r[8]};
    return o;
  endfunction
endpackage
`default_nettype wire

// ===== sv/eight_bit_cpu_subset_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// a bus request is registered and shows on the output the cycle after its input beat
// throughput: one beat per cycle; out_ready low stalls, else output refills as taken
// the core state and the next request come from one combinational step unit
// reset: synchronous active-low, state cleared, first fetch pending
// pc and sp load from the start registers on the first beat after reset
module eight_bit_cpu_subset_core (
  input  wire  logic        clk,
  input  wire  logic        rst_n,
  input  wire  logic        cfg_we,
  input  wire  logic        cfg_index,
  input  wire  logic [15:0] cfg_data,
  input  wire  logic        in_valid,
  output logic              in_ready,
  input  wire  logic [7:0]  in_read_data,
  output logic              out_valid,
  input  wire  logic        out_ready,
  output logic [15:0]       out_bus_address,
  output logic              out_bus_write,
  output logic [7:0]        out_bus_write_data,
  output logic              out_instr_done,
  output logic              out_stopped
);
  ebc_pkg::cpu_state_t st_r, st_nxt;
  ebc_pkg::bus_req_t   req, req_r;
  logic [15:0] start_address_r, start_stack_r;
  logic valid_r;
  logic acc_in;

  assign in_ready = !valid_r || out_ready;
  assign acc_in = in_valid && in_ready;

  ebc_step u_step (
    .s             (st_r),
    .din           (in_read_data),
    .start_address (start_address_r),
    .start_stack   (start_stack_r),
    .n             (st_nxt),
    .req           (req)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
      start_address_r <= 16'd0;
      start_stack_r <= 16'hFFFE;
      valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == ebc_pkg::CFG_START_ADDRESS) begin
          start_address_r <= cfg_data;
        end else begin
          start_stack_r <= cfg_data;
        end
      end
      if (acc_in) begin
        st_r <= st_nxt;
        valid_r <= 1'b1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_in) begin
      req_r <= req;
    end
  end

  assign out_valid = valid_r;
  assign out_bus_address = req_r.addr;
  assign out_bus_write = req_r.wr;
  assign out_bus_write_data = req_r.wdata;
  assign out_instr_done = req_r.done;
  assign out_stopped = req_r.stopped;
endmodule
`default_nettype wire

// ===== sv/ebc_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ebc_step (
  input  wire ebc_pkg::cpu_state_t s,
  input  wire logic [7:0]          din,
  input  wire logic [15:0]         start_address,
  input  wire logic [15:0]         start_stack,
  output ebc_pkg::cpu_state_t      n,
  output ebc_pkg::bus_req_t        req
);
  logic [15:0] bc, de, hl, w, hl_m1;
  ebc_pkg::alu_res_t ar;
  logic fetch_now;
  logic [15:0] pc_inc, sp_dec;

  assign bc = {s.b, s.c};
  assign de = {s.d, s.e};
  assign hl = {s.h, s.l};
  assign hl_m1 = hl - 16'd1;
  assign w = {din, s.imm[7:0]};
  assign pc_inc = s.pc + 16'd1;
  assign sp_dec = s.sp - 16'd1;

  always_comb begin
    n = s;
    req = '0;
    fetch_now = 1'b0;
    ar = '0;
    if (s.halt) begin
      req.addr = s.pc;
      req.stopped = 1'b1;
    end else if (s.ph == ebc_pkg::PH_START) begin
      n.pc = start_address + 16'd1;
      n.sp = start_stack;
      req.addr = start_address;
      req.done = 1'b1;
      n.ph = ebc_pkg::PH_OPC;
    end else if (s.ph == ebc_pkg::PH_OPC) begin
      n.op = din;
      if (s.cb) begin
        n.cb = 1'b0;
        case (din)
          ebc_pkg::CB_RL_C: begin
            n.c = {s.c[6:0], s.f[0]};
            n.f = {{s.c[6:0], s.f[0]} == 8'd0, 2'b00, s.c[7]};
            fetch_now = 1'b1;
          end
          ebc_pkg::CB_BIT7_H: begin
            n.f = {~s.h[7], 1'b0, 1'b1, s.f[0]};
            fetch_now = 1'b1;
          end
          default: begin
            n.pc = s.pc - 16'd1;
            n.halt = 1'b1;
            req.addr = s.pc - 16'd1;
            req.stopped = 1'b1;
          end
        endcase
      end else begin
        case (din)
          ebc_pkg::OP_NOP: fetch_now = 1'b1;
          ebc_pkg::OP_INC_BC: begin
            {n.b, n.c} = bc + 16'd1;
            fetch_now = 1'b1;
          end
          ebc_pkg::OP_DEC_BC: begin
            {n.b, n.c} = bc - 16'd1;
            fetch_now = 1'b1;
          end
          ebc_pkg::OP_INC_SP: begin
            n.sp = s.sp + 16'd1;
            fetch_now = 1'b1;
          end
          ebc_pkg::OP_INC_C: begin
            n.c = s.c + 8'd1;
            n.f = {s.c == 8'hFF, 1'b0, s.c[3:0] == 4'hF, s.f[0]};
            fetch_now = 1'b1;
          end
          ebc_pkg::OP_DEC_C: begin
            n.c = s.c - 8'd1;
            n.f = {s.c == 8'h01, 1'b1, s.c[3:0] == 4'h0, s.f[0]};
            fetch_now = 1'b1;
          end
          ebc_pkg::OP_RLA: begin
            n.a = {s.a[6:0], s.f[0]};
            n.f = {3'b000, s.a[7]};
            fetch_now = 1'b1;
          end
          ebc_pkg::OP_RRA: begin
            n.a = {s.f[0], s.a[7:1]};
            n.f = {3'b000, s.a[0]};
            fetch_now = 1'b1;
          end
          ebc_pkg::OP_LD_C_A: begin
            n.c = s.a;
            fetch_now = 1'b1;
          end
          ebc_pkg::OP_LD_H_E: begin
            n.h = s.e;
            fetch_now = 1'b1;
          end
          ebc_pkg::OP_LD_H_A: begin
            n.h = s.a;
            fetch_now = 1'b1;
          end
          ebc_pkg::OP_ADD_E, ebc_pkg::OP_ADC_B, ebc_pkg::OP_ADC_C: begin
            case (din)
              ebc_pkg::OP_ADD_E: ar = ebc_pkg::alu_add(s.a, s.e, 1'b0);
              ebc_pkg::OP_ADC_B: ar = ebc_pkg::alu_add(s.a, s.b, s.f[0]);
              default:           ar = ebc_pkg::alu_add(s.a, s.c, s.f[0]);
            endcase
            n.a = ar.a;
            n.f = ar.f;
            fetch_now = 1'b1;
          end
          ebc_pkg::OP_SBC_C, ebc_pkg::OP_SBC_A, ebc_pkg::OP_CP_C, ebc_pkg::OP_CP_E: begin
            case (din)
              ebc_pkg::OP_SBC_C: ar = ebc_pkg::alu_sub(s.a, s.c, s.f[0]);
              ebc_pkg::OP_SBC_A: ar = ebc_pkg::alu_sub(s.a, s.a, s.f[0]);
              ebc_pkg::OP_CP_C:  ar = ebc_pkg::alu_sub(s.a, s.c, 1'b0);
              default:           ar = ebc_pkg::alu_sub(s.a, s.e, 1'b0);
            endcase
            if (din inside {ebc_pkg::OP_SBC_C, ebc_pkg::OP_SBC_A}) begin
              n.a = ar.a;
            end
            n.f = ar.f;
            fetch_now = 1'b1;
          end
          ebc_pkg::OP_XOR_A: begin
            n.a = 8'd0;
            n.f = ebc_pkg::FLAG_Z;
            fetch_now = 1'b1;
          end
          ebc_pkg::OP_LD_B_N, ebc_pkg::OP_LD_C_N, ebc_pkg::OP_JR_NZ, ebc_pkg::OP_LD_H_N,
          ebc_pkg::OP_LD_A_N, ebc_pkg::OP_ADC_N, ebc_pkg::OP_LDH_N_A, ebc_pkg::OP_AND_N,
          ebc_pkg::OP_LD_NN_SP, ebc_pkg::OP_LD_DE_NN, ebc_pkg::OP_LD_HL_NN,
          ebc_pkg::OP_LD_SP_NN, ebc_pkg::OP_CALL_Z, ebc_pkg::OP_CALL,
          ebc_pkg::OP_CALL_C: begin
            req.addr = s.pc;
            n.pc = pc_inc;
            n.ph = ebc_pkg::PH_2;
          end
          ebc_pkg::OP_LD_A_DE: begin
            req.addr = de;
            n.ph = ebc_pkg::PH_2;
          end
          ebc_pkg::OP_LD_H_HL, ebc_pkg::OP_LD_L_HL: begin
            req.addr = hl;
            n.ph = ebc_pkg::PH_2;
          end
          ebc_pkg::OP_LDD_HL_A, ebc_pkg::OP_LD_HL_A, ebc_pkg::OP_LD_HL_E: begin
            req.addr = hl;
            req.wr = 1'b1;
            req.wdata = (din == ebc_pkg::OP_LD_HL_E) ? s.e : s.a;
            if (din == ebc_pkg::OP_LDD_HL_A) begin
              {n.h, n.l} = hl_m1;
            end
            n.ph = ebc_pkg::PH_2;
          end
          ebc_pkg::OP_LDH_C_A: begin
            req.addr = {8'hFF, s.c};
            req.wr = 1'b1;
            req.wdata = s.a;
            n.ph = ebc_pkg::PH_2;
          end
          ebc_pkg::OP_POP_BC, ebc_pkg::OP_POP_HL, ebc_pkg::OP_RETI: begin
            req.addr = s.sp;
            n.sp = s.sp + 16'd1;
            n.ph = ebc_pkg::PH_2;
          end
          ebc_pkg::OP_PUSH_BC: begin
            n.sp = sp_dec;
            req.addr = sp_dec;
            req.wr = 1'b1;
            req.wdata = s.b;
            n.ph = ebc_pkg::PH_2;
          end
          ebc_pkg::OP_PREFIX: begin
            n.cb = 1'b1;
            req.addr = s.pc;
            n.pc = pc_inc;
            n.ph = ebc_pkg::PH_OPC;
          end
          default: begin
            n.pc = s.pc - 16'd1;
            n.halt = 1'b1;
            req.addr = s.pc - 16'd1;
            req.stopped = 1'b1;
          end
        endcase
      end
    end else if (s.ph == ebc_pkg::PH_2) begin
      fetch_now = 1'b1;
      case (s.op)
        ebc_pkg::OP_LD_B_N: n.b = din;
        ebc_pkg::OP_LD_C_N: n.c = din;
        ebc_pkg::OP_LD_H_N, ebc_pkg::OP_LD_H_HL: n.h = din;
        ebc_pkg::OP_LD_L_HL: n.l = din;
        ebc_pkg::OP_LD_A_N, ebc_pkg::OP_LD_A_DE: n.a = din;
        ebc_pkg::OP_ADC_N: begin
          ar = ebc_pkg::alu_add(s.a, din, s.f[0]);
          n.a = ar.a;
          n.f = ar.f;
        end
        ebc_pkg::OP_AND_N: begin
          n.a = s.a & din;
          n.f = {(s.a & din) == 8'd0, 1'b0, 1'b1, 1'b0};
        end
        ebc_pkg::OP_JR_NZ: begin
          if (!s.f[3]) begin
            n.pc = s.pc + {{8{din[7]}}, din};
          end
        end
        ebc_pkg::OP_LDH_N_A: begin
          fetch_now = 1'b0;
          req.addr = {8'hFF, din};
          req.wr = 1'b1;
          req.wdata = s.a;
          n.ph = ebc_pkg::PH_3;
        end
        ebc_pkg::OP_LD_NN_SP, ebc_pkg::OP_LD_DE_NN, ebc_pkg::OP_LD_HL_NN,
        ebc_pkg::OP_LD_SP_NN, ebc_pkg::OP_CALL_Z, ebc_pkg::OP_CALL,
        ebc_pkg::OP_CALL_C: begin
          fetch_now = 1'b0;
          n.imm = {8'd0, din};
          req.addr = s.pc;
          n.pc = pc_inc;
          n.ph = ebc_pkg::PH_3;
        end
        ebc_pkg::OP_POP_BC, ebc_pkg::OP_POP_HL, ebc_pkg::OP_RETI: begin
          fetch_now = 1'b0;
          n.imm = {8'd0, din};
          req.addr = s.sp;
          n.sp = s.sp + 16'd1;
          n.ph = ebc_pkg::PH_3;
        end
        ebc_pkg::OP_PUSH_BC: begin
          fetch_now = 1'b0;
          n.sp = sp_dec;
          req.addr = sp_dec;
          req.wr = 1'b1;
          req.wdata = s.c;
          n.ph = ebc_pkg::PH_3;
        end
        default: ;
      endcase
    end else if (s.ph == ebc_pkg::PH_3) begin
      fetch_now = 1'b1;
      case (s.op)
        ebc_pkg::OP_LD_DE_NN: {n.d, n.e} = w;
        ebc_pkg::OP_LD_HL_NN, ebc_pkg::OP_POP_HL: {n.h, n.l} = w;
        ebc_pkg::OP_POP_BC: {n.b, n.c} = w;
        ebc_pkg::OP_LD_SP_NN: n.sp = w;
        ebc_pkg::OP_RETI: begin
          n.pc = w;
          n.ime = 1'b1;
        end
        ebc_pkg::OP_LD_NN_SP: begin
          fetch_now = 1'b0;
          n.imm = w;
          req.addr = w;
          req.wr = 1'b1;
          req.wdata = s.sp[7:0];
          n.ph = ebc_pkg::PH_4;
        end
        ebc_pkg::OP_CALL_Z, ebc_pkg::OP_CALL, ebc_pkg::OP_CALL_C: begin
          n.imm = w;
          if (!((s.op == ebc_pkg::OP_CALL_Z && !s.f[3]) ||
                (s.op == ebc_pkg::OP_CALL_C && !s.f[0]))) begin
            fetch_now = 1'b0;
            n.sp = sp_dec;
            req.addr = sp_dec;
            req.wr = 1'b1;
            req.wdata = s.pc[15:8];
            n.ph = ebc_pkg::PH_4;
          end
        end
        default: ;
      endcase
    end else if (s.ph == ebc_pkg::PH_4) begin
      fetch_now = 1'b1;
      if (s.op == ebc_pkg::OP_LD_NN_SP) begin
        fetch_now = 1'b0;
        req.addr = s.imm + 16'd1;
        req.wr = 1'b1;
        req.wdata = s.sp[15:8];
        n.ph = ebc_pkg::PH_5;
      end else if (s.op inside {ebc_pkg::OP_CALL_Z, ebc_pkg::OP_CALL, ebc_pkg::OP_CALL_C}) begin
        fetch_now = 1'b0;
        n.sp = sp_dec;
        req.addr = sp_dec;
        req.wr = 1'b1;
        req.wdata = s.pc[7:0];
        n.ph = ebc_pkg::PH_5;
      end
    end else begin
      fetch_now = 1'b1;
      if (s.ph == ebc_pkg::PH_5 &&
          (s.op inside {ebc_pkg::OP_CALL_Z, ebc_pkg::OP_CALL, ebc_pkg::OP_CALL_C})) begin
        n.pc = s.imm;
      end
    end
    if (fetch_now) begin
      req.addr = n.pc;
      req.done = 1'b1;
      n.pc = n.pc + 16'd1;
      n.ph = ebc_pkg::PH_OPC;
    end
  end
endmodule
`default_nettype wire

// ===== tb/tb_eight_bit_cpu_subset_core.sv =====
`timescale 1ns / 1ps
module tb_eight_bit_cpu_subset_core;
  localparam int N_OPS = 46;

  logic [7:0] op_set [0:N_OPS-1] = '{
    ebc_pkg::OP_NOP, ebc_pkg::OP_INC_BC, ebc_pkg::OP_LD_B_N, ebc_pkg::OP_LD_NN_SP,
    ebc_pkg::OP_DEC_BC, ebc_pkg::OP_INC_C, ebc_pkg::OP_DEC_C, ebc_pkg::OP_LD_C_N,
    ebc_pkg::OP_LD_DE_NN, ebc_pkg::OP_RLA, ebc_pkg::OP_LD_A_DE, ebc_pkg::OP_RRA,
    ebc_pkg::OP_JR_NZ, ebc_pkg::OP_LD_HL_NN, ebc_pkg::OP_LD_H_N, ebc_pkg::OP_LD_SP_NN,
    ebc_pkg::OP_LDD_HL_A, ebc_pkg::OP_INC_SP, ebc_pkg::OP_LD_A_N, ebc_pkg::OP_LD_C_A,
    ebc_pkg::OP_LD_H_E, ebc_pkg::OP_LD_H_HL, ebc_pkg::OP_LD_H_A, ebc_pkg::OP_LD_L_HL,
    ebc_pkg::OP_LD_HL_E, ebc_pkg::OP_LD_HL_A, ebc_pkg::OP_ADD_E, ebc_pkg::OP_ADC_B,
    ebc_pkg::OP_ADC_C, ebc_pkg::OP_SBC_C, ebc_pkg::OP_SBC_A, ebc_pkg::OP_XOR_A,
    ebc_pkg::OP_CP_C, ebc_pkg::OP_CP_E, ebc_pkg::OP_POP_BC, ebc_pkg::OP_PUSH_BC,
    ebc_pkg::OP_PREFIX, ebc_pkg::OP_CALL_Z, ebc_pkg::OP_CALL, ebc_pkg::OP_ADC_N,
    ebc_pkg::OP_RETI, ebc_pkg::OP_CALL_C, ebc_pkg::OP_LDH_N_A, ebc_pkg::OP_POP_HL,
    ebc_pkg::OP_LDH_C_A, ebc_pkg::OP_AND_N};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = ebc_pkg::CFG_START_ADDRESS;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_read_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_bus_address;
  logic        out_bus_write;
  logic [7:0]  out_bus_write_data;
  logic        out_instr_done;
  logic        out_stopped;

  eight_bit_cpu_subset_core uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_read_data(in_read_data),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_bus_address(out_bus_address), .out_bus_write(out_bus_write),
    .out_bus_write_data(out_bus_write_data), .out_instr_done(out_instr_done),
    .out_stopped(out_stopped)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  logic [15:0]         start_pc_reg = 16'h0000;
  logic [15:0]         start_sp_reg = 16'hFFFE;
  ebc_pkg::cpu_state_t core_model;
  ebc_pkg::cpu_state_t fetch_view;
  logic [7:0]          pending_bytes [$];
  ebc_pkg::bus_req_t   expected_reqs [$];
  int                  send_idle = 0;
  int                  recv_idle = 0;
  int                  n_errors = 0;
  int                  n_beats = 0;
  int                  n_done = 0;
  int                  n_writes = 0;
  int                  n_gen = 0;
  logic                data_beat = 1'b0;

  function automatic void put_req(inout ebc_pkg::cpu_state_t s, output ebc_pkg::bus_req_t r,
                                  input logic [15:0] addr, input logic wr,
                                  input logic [7:0] data, input logic dn);
    r.addr = addr;
    r.wr = wr;
    r.wdata = wr ? data : 8'h00;
    r.done = dn;
    r.stopped = s.halt;
  endfunction

  function automatic void take_fetch(inout ebc_pkg::cpu_state_t s,
                                     output ebc_pkg::bus_req_t r, input logic dn);
    put_req(s, r, s.pc, 1'b0, 8'h00, dn);
    s.pc = s.pc + 16'd1;
    s.ph = ebc_pkg::PH_OPC;
  endfunction

  function automatic void read_pc(inout ebc_pkg::cpu_state_t s, output ebc_pkg::bus_req_t r,
                                  input logic [2:0] nx);
    put_req(s, r, s.pc, 1'b0, 8'h00, 1'b0);
    s.pc = s.pc + 16'd1;
    s.ph = nx;
  endfunction

  function automatic void read_sp(inout ebc_pkg::cpu_state_t s, output ebc_pkg::bus_req_t r,
                                  input logic [2:0] nx);
    put_req(s, r, s.sp, 1'b0, 8'h00, 1'b0);
    s.sp = s.sp + 16'd1;
    s.ph = nx;
  endfunction

  function automatic void push_byte(inout ebc_pkg::cpu_state_t s,
                                    output ebc_pkg::bus_req_t r,
                                    input logic [7:0] v, input logic [2:0] nx);
    s.sp = s.sp - 16'd1;
    put_req(s, r, s.sp, 1'b1, v, 1'b0);
    s.ph = nx;
  endfunction

  function automatic void halt_core(inout ebc_pkg::cpu_state_t s,
                                    output ebc_pkg::bus_req_t r);
    s.pc = s.pc - 16'd1;
    s.halt = 1'b1;
    put_req(s, r, s.pc, 1'b0, 8'h00, 1'b0);
  endfunction

  function automatic void add8(inout ebc_pkg::cpu_state_t s, input logic [7:0] b,
                               input logic cin);
    logic [8:0] sum;
    logic       hc;
    sum = {1'b0, s.a} + {1'b0, b} + {8'd0, cin};
    hc = ({1'b0, s.a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin}) > 5'd15;
    s.f = {sum[7:0] == 8'd0, 1'b0, hc, sum[8]};
    s.a = sum[7:0];
  endfunction

  function automatic void sub8(inout ebc_pkg::cpu_state_t s, input logic [7:0] b,
                               input logic cin, input logic keep);
    int ai;
    int bi;
    logic [7:0] dif;
    ai = s.a;
    bi = b;
    dif = 8'((ai - bi - int'(cin)) & 255);
    s.f = {dif == 8'd0, 1'b1, (ai & 15) < (bi & 15) + int'(cin), ai < bi + int'(cin)};
    if (keep) s.a = dif;
  endfunction

  function automatic void cpu_step(inout ebc_pkg::cpu_state_t s, input logic [7:0] din,
                                   output ebc_pkg::bus_req_t r);
    logic       fin;
    logic       nc;
    logic [15:0] w;
    fin = 1'b0;
    r = '0;
    if (s.halt) begin
      put_req(s, r, s.pc, 1'b0, 8'h00, 1'b0);
      return;
    end
    case (s.ph)
      ebc_pkg::PH_START: begin
        s.pc = start_pc_reg;
        s.sp = start_sp_reg;
        fin = 1'b1;
      end
      ebc_pkg::PH_OPC: begin
        s.op = din;
        if (s.cb) begin
          s.cb = 1'b0;
          case (din)
            ebc_pkg::CB_RL_C: begin
              nc = s.c[7];
              s.c = {s.c[6:0], s.f[0]};
              s.f = {s.c == 8'd0, 2'b00, nc};
              fin = 1'b1;
            end
            ebc_pkg::CB_BIT7_H: begin
              s.f = (s.f & ebc_pkg::FLAG_C) | ebc_pkg::FLAG_H |
                    (s.h[7] ? 4'h0 : ebc_pkg::FLAG_Z);
              fin = 1'b1;
            end
            default: halt_core(s, r);
          endcase
        end else begin
          fin = 1'b1;
          case (din)
            ebc_pkg::OP_NOP: ;
            ebc_pkg::OP_INC_BC: {s.b, s.c} = {s.b, s.c} + 16'd1;
            ebc_pkg::OP_DEC_BC: {s.b, s.c} = {s.b, s.c} - 16'd1;
            ebc_pkg::OP_INC_SP: s.sp = s.sp + 16'd1;
            ebc_pkg::OP_INC_C: begin
              s.f = (s.f & ebc_pkg::FLAG_C) | ((s.c[3:0] == 4'hF) ? ebc_pkg::FLAG_H : 4'h0);
              s.c = s.c + 8'd1;
              if (s.c == 8'd0) s.f = s.f | ebc_pkg::FLAG_Z;
            end
            ebc_pkg::OP_DEC_C: begin
              s.f = (s.f & ebc_pkg::FLAG_C) | ebc_pkg::FLAG_N |
                    ((s.c[3:0] == 4'h0) ? ebc_pkg::FLAG_H : 4'h0);
              s.c = s.c - 8'd1;
              if (s.c == 8'd0) s.f = s.f | ebc_pkg::FLAG_Z;
            end
            ebc_pkg::OP_RLA: begin
              nc = s.a[7];
              s.a = {s.a[6:0], s.f[0]};
              s.f = {3'b000, nc};
            end
            ebc_pkg::OP_RRA: begin
              nc = s.a[0];
              s.a = {s.f[0], s.a[7:1]};
              s.f = {3'b000, nc};
            end
            ebc_pkg::OP_LD_C_A: s.c = s.a;
            ebc_pkg::OP_LD_H_E: s.h = s.e;
            ebc_pkg::OP_LD_H_A: s.h = s.a;
            ebc_pkg::OP_ADD_E: add8(s, s.e, 1'b0);
            ebc_pkg::OP_ADC_B: add8(s, s.b, s.f[0]);
            ebc_pkg::OP_ADC_C: add8(s, s.c, s.f[0]);
            ebc_pkg::OP_SBC_C: sub8(s, s.c, s.f[0], 1'b1);
            ebc_pkg::OP_SBC_A: sub8(s, s.a, s.f[0], 1'b1);
            ebc_pkg::OP_XOR_A: begin
              s.a = 8'h00;
              s.f = ebc_pkg::FLAG_Z;
            end
            ebc_pkg::OP_CP_C: sub8(s, s.c, 1'b0, 1'b0);
            ebc_pkg::OP_CP_E: sub8(s, s.e, 1'b0, 1'b0);
            ebc_pkg::OP_LD_B_N, ebc_pkg::OP_LD_C_N, ebc_pkg::OP_JR_NZ, ebc_pkg::OP_LD_H_N,
            ebc_pkg::OP_LD_A_N, ebc_pkg::OP_ADC_N, ebc_pkg::OP_LDH_N_A, ebc_pkg::OP_AND_N,
            ebc_pkg::OP_LD_NN_SP, ebc_pkg::OP_LD_DE_NN, ebc_pkg::OP_LD_HL_NN,
            ebc_pkg::OP_LD_SP_NN, ebc_pkg::OP_CALL_Z, ebc_pkg::OP_CALL,
            ebc_pkg::OP_CALL_C: begin
              fin = 1'b0;
              read_pc(s, r, ebc_pkg::PH_2);
            end
            ebc_pkg::OP_LD_A_DE: begin
              fin = 1'b0;
              put_req(s, r, {s.d, s.e}, 1'b0, 8'h00, 1'b0);
              s.ph = ebc_pkg::PH_2;
            end
            ebc_pkg::OP_LD_H_HL, ebc_pkg::OP_LD_L_HL: begin
              fin = 1'b0;
              put_req(s, r, {s.h, s.l}, 1'b0, 8'h00, 1'b0);
              s.ph = ebc_pkg::PH_2;
            end
            ebc_pkg::OP_LDD_HL_A: begin
              fin = 1'b0;
              put_req(s, r, {s.h, s.l}, 1'b1, s.a, 1'b0);
              {s.h, s.l} = {s.h, s.l} - 16'd1;
              s.ph = ebc_pkg::PH_2;
            end
            ebc_pkg::OP_LD_HL_E, ebc_pkg::OP_LD_HL_A: begin
              fin = 1'b0;
              put_req(s, r, {s.h, s.l}, 1'b1, (din == ebc_pkg::OP_LD_HL_E) ? s.e : s.a,
                      1'b0);
              s.ph = ebc_pkg::PH_2;
            end
            ebc_pkg::OP_LDH_C_A: begin
              fin = 1'b0;
              put_req(s, r, {8'hFF, s.c}, 1'b1, s.a, 1'b0);
              s.ph = ebc_pkg::PH_2;
            end
            ebc_pkg::OP_POP_BC, ebc_pkg::OP_POP_HL, ebc_pkg::OP_RETI: begin
              fin = 1'b0;
              read_sp(s, r, ebc_pkg::PH_2);
            end
            ebc_pkg::OP_PUSH_BC: begin
              fin = 1'b0;
              push_byte(s, r, s.b, ebc_pkg::PH_2);
            end
            ebc_pkg::OP_PREFIX: begin
              fin = 1'b0;
              s.cb = 1'b1;
              take_fetch(s, r, 1'b0);
            end
            default: begin
              fin = 1'b0;
              halt_core(s, r);
            end
          endcase
        end
      end
      ebc_pkg::PH_2: begin
        fin = 1'b1;
        case (s.op)
          ebc_pkg::OP_LD_B_N: s.b = din;
          ebc_pkg::OP_LD_C_N: s.c = din;
          ebc_pkg::OP_LD_H_N, ebc_pkg::OP_LD_H_HL: s.h = din;
          ebc_pkg::OP_LD_L_HL: s.l = din;
          ebc_pkg::OP_LD_A_N, ebc_pkg::OP_LD_A_DE: s.a = din;
          ebc_pkg::OP_ADC_N: add8(s, din, s.f[0]);
          ebc_pkg::OP_AND_N: begin
            s.a = s.a & din;
            s.f = ((s.a == 8'd0) ? ebc_pkg::FLAG_Z : 4'h0) | ebc_pkg::FLAG_H;
          end
          ebc_pkg::OP_JR_NZ:
            if ((s.f & ebc_pkg::FLAG_Z) == 4'h0) s.pc = s.pc + {{8{din[7]}}, din};
          ebc_pkg::OP_LDH_N_A: begin
            fin = 1'b0;
            put_req(s, r, {8'hFF, din}, 1'b1, s.a, 1'b0);
            s.ph = ebc_pkg::PH_3;
          end
          ebc_pkg::OP_LD_NN_SP, ebc_pkg::OP_LD_DE_NN, ebc_pkg::OP_LD_HL_NN,
          ebc_pkg::OP_LD_SP_NN, ebc_pkg::OP_CALL_Z, ebc_pkg::OP_CALL,
          ebc_pkg::OP_CALL_C: begin
            fin = 1'b0;
            s.imm = {8'h00, din};
            read_pc(s, r, ebc_pkg::PH_3);
          end
          ebc_pkg::OP_POP_BC, ebc_pkg::OP_POP_HL, ebc_pkg::OP_RETI: begin
            fin = 1'b0;
            s.imm = {8'h00, din};
            read_sp(s, r, ebc_pkg::PH_3);
          end
          ebc_pkg::OP_PUSH_BC: begin
            fin = 1'b0;
            push_byte(s, r, s.c, ebc_pkg::PH_3);
          end
          default: ;
        endcase
      end
      ebc_pkg::PH_3: begin
        fin = 1'b1;
        w = {din, s.imm[7:0]};
        case (s.op)
          ebc_pkg::OP_LD_DE_NN: {s.d, s.e} = w;
          ebc_pkg::OP_LD_HL_NN, ebc_pkg::OP_POP_HL: {s.h, s.l} = w;
          ebc_pkg::OP_POP_BC: {s.b, s.c} = w;
          ebc_pkg::OP_LD_SP_NN: s.sp = w;
          ebc_pkg::OP_RETI: begin
            s.pc = w;
            s.ime = 1'b1;
          end
          ebc_pkg::OP_LD_NN_SP: begin
            fin = 1'b0;
            s.imm = w;
            put_req(s, r, w, 1'b1, s.sp[7:0], 1'b0);
            s.ph = ebc_pkg::PH_4;
          end
          ebc_pkg::OP_CALL_Z, ebc_pkg::OP_CALL, ebc_pkg::OP_CALL_C: begin
            s.imm = w;
            if (!((s.op == ebc_pkg::OP_CALL_Z && (s.f & ebc_pkg::FLAG_Z) == 4'h0) ||
                  (s.op == ebc_pkg::OP_CALL_C && (s.f & ebc_pkg::FLAG_C) == 4'h0))) begin
              fin = 1'b0;
              push_byte(s, r, s.pc[15:8], ebc_pkg::PH_4);
            end
          end
          default: ;
        endcase
      end
      ebc_pkg::PH_4: begin
        fin = 1'b1;
        if (s.op == ebc_pkg::OP_LD_NN_SP) begin
          fin = 1'b0;
          put_req(s, r, s.imm + 16'd1, 1'b1, s.sp[15:8], 1'b0);
          s.ph = ebc_pkg::PH_5;
        end else if (s.op inside {ebc_pkg::OP_CALL_Z, ebc_pkg::OP_CALL, ebc_pkg::OP_CALL_C})
        begin
          fin = 1'b0;
          push_byte(s, r, s.pc[7:0], ebc_pkg::PH_5);
        end
      end
      ebc_pkg::PH_5: begin
        fin = 1'b1;
        if (s.op inside {ebc_pkg::OP_CALL_Z, ebc_pkg::OP_CALL, ebc_pkg::OP_CALL_C})
          s.pc = s.imm;
      end
      default: fin = 1'b1;
    endcase
    if (fin) take_fetch(s, r, 1'b1);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    n_errors++;
    $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
  endtask

  task automatic gen_byte(input logic [7:0] b);
    ebc_pkg::bus_req_t scratch;
    pending_bytes.push_back(b);
    cpu_step(fetch_view, b, scratch);
    n_gen++;
  endtask

  function automatic logic [7:0] rand_operand();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // opnd < 0 gives random operand bytes
  task automatic gen_instr(input logic [7:0] op, input int opnd);
    gen_byte(op);
    while (fetch_view.ph != ebc_pkg::PH_OPC && !fetch_view.halt)
      gen_byte(opnd < 0 ? rand_operand() : 8'(opnd));
  endtask

  task automatic gen_random_instr();
    logic [7:0] op;
    op = op_set[$urandom_range(0, N_OPS - 1)];
    gen_instr(op, -1);
    if (op == ebc_pkg::OP_PREFIX)
      gen_instr($urandom_range(0, 1) ? ebc_pkg::CB_RL_C : ebc_pkg::CB_BIT7_H, -1);
  endtask

  function automatic logic is_known(input logic [7:0] op);
    foreach (op_set[i]) if (op_set[i] == op) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic [15:0] pick_start();
    case ($urandom_range(0, 3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic cfg_write(input logic idx, input logic [15:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    if (idx == ebc_pkg::CFG_START_ADDRESS) start_pc_reg = v;
    else start_sp_reg = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending_bytes.size() != 0 || expected_reqs.size() != 0 || in_valid)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // input beat taken: advance the model
  always @(posedge clk) begin
    ebc_pkg::bus_req_t nxt;
    data_beat = rst_n && in_valid && in_ready;
    if (data_beat) begin
      cpu_step(core_model, in_read_data, nxt);
      expected_reqs.push_back(nxt);
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || data_beat) begin
      if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
        in_valid <= 1'b1;
        in_read_data <= pending_bytes.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= rst_n && ($urandom_range(0, 99) >= recv_idle);
  end

  always @(posedge clk) begin
    ebc_pkg::bus_req_t want;
    if (rst_n && out_valid && out_ready) begin
      n_beats++;
      if (out_instr_done) n_done++;
      if (out_bus_write) n_writes++;
      if (expected_reqs.size() == 0) begin
        report_mismatch("unexpected beat", out_bus_address, 0);
      end else begin
        want = expected_reqs.pop_front();
        if (out_bus_address !== want.addr)
          report_mismatch("bus_address", out_bus_address, want.addr);
        if (out_bus_write !== want.wr)
          report_mismatch("bus_write", out_bus_write, want.wr);
        if (out_bus_write_data !== want.wdata)
          report_mismatch("bus_write_data", out_bus_write_data, want.wdata);
        if (out_instr_done !== want.done)
          report_mismatch("instr_done", out_instr_done, want.done);
        if (out_stopped !== want.stopped)
          report_mismatch("stopped", out_stopped, want.stopped);
      end
    end
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    logic [7:0] bad;
    int target;
    core_model = '0;
    fetch_view = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    cfg_write(ebc_pkg::CFG_START_ADDRESS, pick_start());
    cfg_write(ebc_pkg::CFG_START_STACK, pick_start());

    for (int p = 0; p < 3; p++) begin
      send_idle = (p == 0) ? 30 : (p == 1) ? 54 : 0;
      recv_idle = (p == 0) ? 54 : (p == 1) ? 30 : 0;
      if (p == 0) begin
        gen_byte(rand_operand());
        gen_instr(ebc_pkg::OP_LD_A_N, 8'hFF);
        gen_instr(ebc_pkg::OP_ADC_N, 8'h01);
        gen_instr(ebc_pkg::OP_PREFIX, 0);
        gen_instr(ebc_pkg::CB_RL_C, 0);
        gen_instr(ebc_pkg::OP_PREFIX, 0);
        gen_instr(ebc_pkg::CB_BIT7_H, 0);
        gen_instr(ebc_pkg::OP_JR_NZ, 8'h80);
        gen_instr(ebc_pkg::OP_CALL_C, 8'hFF);
        gen_instr(ebc_pkg::OP_CALL_Z, 8'h00);
        gen_instr(ebc_pkg::OP_LD_NN_SP, 8'hFF);
        gen_instr(ebc_pkg::OP_LDH_N_A, 8'h00);
      end
      target = n_gen + 530;
      while (n_gen < target) gen_random_instr();
      drain();
      cfg_write(ebc_pkg::CFG_START_ADDRESS, (p == 0) ? 16'hFFFF : 16'h0000);
      cfg_write(ebc_pkg::CFG_START_STACK, (p == 0) ? 16'h0000 : 16'hFFFF);
    end

    // halt: stop, an unknown opcode, or an unknown prefixed opcode
    case ($urandom_range(0, 2))
      0: gen_byte(ebc_pkg::OP_STOP);
      1: begin
        do bad = 8'($urandom_range(0, 255)); while (is_known(bad));
        gen_byte(bad);
      end
      default: begin
        gen_byte(ebc_pkg::OP_PREFIX);
        do bad = 8'($urandom_range(0, 255));
        while (bad == ebc_pkg::CB_RL_C || bad == ebc_pkg::CB_BIT7_H);
        gen_byte(bad);
      end
    endcase
    repeat (6) gen_byte(rand_operand());
    drain();

    $display("ran %0d bus beats: %0d instruction fetches, %0d write beats", n_beats, n_done,
             n_writes);
    $display("three handshake pressure mixes, start registers at extremes, halt at the end");
    if (n_errors == 0 && expected_reqs.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
sv/ebc_pkg.sv
sv/ebc_step.sv
sv/eight_bit_cpu_subset_core.sv
tb/tb_eight_bit_cpu_subset_core.sv
